[hw/rtl/ssr_pkg.sv]
// ----------------------------------------------------------------------------
// ssr_pkg
// Shared types, widths, constants and the digit pattern table of the
// smoothed sensor readout.
// ----------------------------------------------------------------------------
package ssr_pkg;

  localparam int SAMPLE_BITS   = 12;
  localparam int FRACTION_BITS = 16;

  localparam int VREF_W    = 13;
  localparam int LEN_W     = 10;
  localparam int SEG_W     = 8;
  localparam int OUT_W     = 13;
  localparam int DIGIT_W   = 4;
  localparam int DIGITS    = 3;
  localparam int DIG_IDX_W = 2;
  localparam int CFG_IDX_W = 1;

  localparam int PROD_W    = SAMPLE_BITS + VREF_W;
  localparam int CEL_PRE   = FRACTION_BITS - SAMPLE_BITS;
  localparam int CX_W      = PROD_W + CEL_PRE;
  localparam int CREC_W    = 28;
  localparam int CEL_SHIFT = 31;
  localparam int CPROD_W   = CX_W + CREC_W;
  localparam int CQ_W      = CPROD_W - CEL_SHIFT;
  localparam int CEL_W     = FRACTION_BITS + 11;
  localparam int ACC_W     = FRACTION_BITS + 21;
  localparam int FAH_W     = FRACTION_BITS + 17;
  localparam int RD_W      = 14;
  localparam int DREC_W    = 13;
  localparam int DIG_SHIFT = 16;
  localparam int DPROD_W   = RD_W + DREC_W;
  localparam int DQ_W      = DPROD_W - DIG_SHIFT;
  localparam int DIVD_W    = ACC_W;
  localparam int DIVS_W    = LEN_W + 1;
  localparam int CNT_W     = $clog2(DIVD_W + 1);

  localparam logic [VREF_W-1:0]        VREF_RESET  = VREF_W'(3270);
  localparam logic [LEN_W-1:0]         LEN_RESET   = LEN_W'(30);
  localparam logic [OUT_W-1:0]         READING_MAX = OUT_W'(7000);
  localparam logic [CX_W-1:0]          CEL_ROUND   = CX_W'(5);
  localparam logic [CREC_W-1:0]        CEL_RECIP   = CREC_W'(214748365);
  localparam logic signed [CEL_W-1:0]  CEL_OFFSET  = CEL_W'(50) << FRACTION_BITS;
  localparam logic signed [FAH_W-1:0]  FAH_SCALE   = FAH_W'(18);
  localparam logic signed [FAH_W-1:0]  FAH_OFFSET  = FAH_W'(320) << FRACTION_BITS;
  localparam logic [FAH_W-1:0]         FAH_HALF    = FAH_W'(1) << (FRACTION_BITS - 1);
  localparam logic [DREC_W-1:0]        DIG_RECIP   = DREC_W'(6554);
  localparam logic [RD_W-1:0]          DEC_BASE    = RD_W'(10);
  localparam logic [SEG_W-1:0]         SEG_DP      = 8'h80;

  localparam logic [CFG_IDX_W-1:0] REG_VREF    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_AVG_LEN = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CMUL,
    ST_CDIV,
    ST_CSUB,
    ST_AMUL,
    ST_ADIV_LD,
    ST_ADIV,
    ST_AUPD,
    ST_FMUL,
    ST_FRND,
    ST_DST,
    ST_OUT
  } ssr_state_e;

  typedef struct packed {
    logic                 in_load;
    logic                 cel_mul;
    logic                 cel_div;
    logic                 div_start;
    logic                 cel_store;
    logic                 avg_mul;
    logic                 avg_store;
    logic                 fah_mul;
    logic                 fah_round;
    logic                 dig_store;
    logic [DIG_IDX_W-1:0] dig_idx;
    logic                 out_load;
  } ssr_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic primed;
  } ssr_stat_t;

  function automatic logic [SEG_W-1:0] seg_of(logic [DIGIT_W-1:0] digit, logic point);
    logic [SEG_W-1:0] pat;
    case (digit)
      4'd0: pat = 8'h3F;
      4'd1: pat = 8'h06;
      4'd2: pat = 8'h5B;
      4'd3: pat = 8'h4F;
      4'd4: pat = 8'h66;
      4'd5: pat = 8'h6D;
      4'd6: pat = 8'h7D;
      4'd7: pat = 8'h07;
      4'd8: pat = 8'h7F;
      4'd9: pat = 8'h6F;
      default: pat = 8'h00;
    endcase
    if (point) begin
      pat = pat | SEG_DP;
    end
    return ~pat;
  endfunction

endpackage

[hw/rtl/ssr_divider.sv]
// ----------------------------------------------------------------------------
// ssr_divider
// Restoring divider for the running average update, one quotient bit per
// cycle over a left-aligned dividend.
// ----------------------------------------------------------------------------
module ssr_divider
  import ssr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIVD_W-1:0] dividend_i,
  input  logic [DIVS_W-1:0] divisor_i,
  input  logic [CNT_W-1:0]  count_i,
  output logic              busy_o,
  output logic [DIVD_W-1:0] quot_o
);

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DIVD_W-1:0] quot_q, quot_d;
  logic [DIVS_W-1:0] rem_q, rem_d;
  logic [DIVS_W-1:0] dvs_q;
  logic [DIVS_W:0]   rem_sh;
  logic [DIVS_W:0]   rem_sub;
  logic              ge;

  assign busy_o  = (cnt_q != '0);
  assign rem_sh  = {rem_q, quot_q[DIVD_W-1]};
  assign ge      = (rem_sh >= {1'b0, dvs_q});
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_comb begin
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    if (start_i) begin
      cnt_d  = count_i;
      quot_d = dividend_i;
      rem_d  = '0;
    end else if (busy_o) begin
      cnt_d  = cnt_q - CNT_W'(1);
      quot_d = {quot_q[DIVD_W-2:0], ge};
      rem_d  = ge ? rem_sub[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign quot_o = quot_q;

endmodule

[hw/rtl/ssr_datapath.sv]
// ----------------------------------------------------------------------------
// ssr_datapath
// Configuration registers, Celsius conversion, running average, Fahrenheit
// rounding, digit extraction and the output register.
// ----------------------------------------------------------------------------
module ssr_datapath
  import ssr_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [VREF_W-1:0]      cfg_data_i,
  input  logic [SAMPLE_BITS-1:0] adc_sample_i,
  input  ssr_cmd_t               cmd_i,
  output ssr_stat_t              stat_o,
  output logic [SEG_W-1:0]       hundreds_segments_o,
  output logic [SEG_W-1:0]       tens_segments_o,
  output logic [SEG_W-1:0]       units_segments_o,
  output logic [OUT_W-1:0]       reading_tenths_o
);

  logic [VREF_W-1:0]        vref_q;
  logic [LEN_W-1:0]         len_q;
  logic                     primed_q;
  logic [SAMPLE_BITS-1:0]   sample_q;
  logic [PROD_W-1:0]        prod_q;
  logic [CQ_W-1:0]          cel_quot_q;
  logic signed [CEL_W-1:0]  celsius_q;
  logic signed [CEL_W-1:0]  avg_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [FAH_W-1:0]  fah_q;
  logic [RD_W-1:0]          reading_q;
  logic [RD_W-1:0]          num_q;
  logic [DIGIT_W-1:0]       dig_q [DIGITS];
  logic [SEG_W-1:0]         hundreds_q;
  logic [SEG_W-1:0]         tens_q;
  logic [SEG_W-1:0]         units_q;
  logic [OUT_W-1:0]         reading_out_q;

  logic [LEN_W-1:0]            n_eff;
  logic [LEN_W-1:0]            n_m1;
  logic [CX_W-1:0]             cel_x;
  logic [CPROD_W-1:0]          cel_prod;
  logic signed [CEL_W-1:0]     celsius_d;
  logic signed [CEL_W+LEN_W:0] avg_prod;
  logic signed [ACC_W-1:0]     acc_d;
  logic [ACC_W-1:0]            acc_mag;
  logic signed [CEL_W-1:0]     avg_quot;
  logic signed [FAH_W-1:0]     fah_d;
  logic [FAH_W-1:0]            fah_rnd;
  logic [RD_W-1:0]             reading_d;
  logic [OUT_W-1:0]            reading_sat;
  logic [DPROD_W-1:0]          dig_prod;
  logic [DQ_W-1:0]             dig_quot;
  logic [RD_W-1:0]             dig_rem;

  logic                        div_busy;
  logic [DIVD_W-1:0]           div_quot;
  logic [DIVD_W-1:0]           div_dividend;
  logic [DIVS_W-1:0]           div_divisor;
  logic [CNT_W-1:0]            div_count;

  assign n_eff = (len_q == '0) ? LEN_W'(1) : len_q;
  assign n_m1  = n_eff - LEN_W'(1);

  assign cel_x     = {prod_q, {CEL_PRE{1'b0}}} + CEL_ROUND;
  assign cel_prod  = CPROD_W'(cel_x) * CPROD_W'(CEL_RECIP);
  assign celsius_d = $signed(CEL_W'(cel_quot_q)) - CEL_OFFSET;

  assign avg_prod = avg_q * $signed({1'b0, n_m1});
  assign acc_d    = ACC_W'(avg_prod) + ACC_W'(celsius_q);
  assign acc_mag  = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
  assign avg_quot = $signed(div_quot[CEL_W-1:0]);

  assign fah_d     = FAH_W'(avg_q) * FAH_SCALE + FAH_OFFSET;
  assign fah_rnd   = FAH_W'(fah_q) + FAH_HALF;
  assign reading_d = fah_q[FAH_W-1] ? '0 : fah_rnd[FRACTION_BITS+RD_W-1:FRACTION_BITS];

  assign reading_sat = (OUT_W'(reading_q) > READING_MAX || reading_q[RD_W-1])
                       ? READING_MAX : OUT_W'(reading_q);

  assign dig_prod = DPROD_W'(num_q) * DPROD_W'(DIG_RECIP);
  assign dig_quot = dig_prod[DPROD_W-1:DIG_SHIFT];
  assign dig_rem  = num_q - RD_W'(dig_quot) * DEC_BASE;

  assign div_dividend = {acc_mag[ACC_W-2:0], 1'b0} + DIVD_W'(n_eff);
  assign div_divisor  = {n_eff, 1'b0};
  assign div_count    = CNT_W'(DIVD_W);

  ssr_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .count_i    (div_count),
    .busy_o     (div_busy),
    .quot_o     (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vref_q   <= VREF_RESET;
      len_q    <= LEN_RESET;
      primed_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_VREF:    vref_q <= cfg_data_i;
          REG_AVG_LEN: len_q  <= cfg_data_i[LEN_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd_i.cel_store) begin
        primed_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      sample_q <= adc_sample_i;
    end
    if (cmd_i.cel_mul) begin
      prod_q <= PROD_W'(sample_q) * PROD_W'(vref_q);
    end
    if (cmd_i.cel_div) begin
      cel_quot_q <= cel_prod[CPROD_W-1:CEL_SHIFT];
    end
    if (cmd_i.cel_store) begin
      celsius_q <= celsius_d;
      if (!primed_q) begin
        avg_q <= celsius_d;
      end
    end
    if (cmd_i.avg_mul) begin
      acc_q <= acc_d;
    end
    if (cmd_i.avg_store) begin
      avg_q <= acc_q[ACC_W-1] ? -avg_quot : avg_quot;
    end
    if (cmd_i.fah_mul) begin
      fah_q <= fah_d;
    end
    if (cmd_i.fah_round) begin
      reading_q <= reading_d;
      num_q     <= reading_d;
    end
    if (cmd_i.dig_store) begin
      dig_q[cmd_i.dig_idx] <= dig_rem[DIGIT_W-1:0];
      num_q                <= RD_W'(dig_quot);
    end
    if (cmd_i.out_load) begin
      hundreds_q    <= seg_of(dig_q[2], 1'b0);
      tens_q        <= seg_of(dig_q[1], 1'b1);
      units_q       <= seg_of(dig_q[0], 1'b0);
      reading_out_q <= reading_sat;
    end
  end

  assign stat_o.div_busy = div_busy;
  assign stat_o.primed   = primed_q;

  assign hundreds_segments_o = hundreds_q;
  assign tens_segments_o     = tens_q;
  assign units_segments_o    = units_q;
  assign reading_tenths_o    = reading_out_q;

endmodule

[hw/rtl/ssr_controller.sv]
// ----------------------------------------------------------------------------
// ssr_controller
// Sequencer that steps one item through the datapath and owns the input and
// output handshakes.
// ----------------------------------------------------------------------------
module ssr_controller
  import ssr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  ssr_stat_t stat_i,
  output ssr_cmd_t  cmd_o
);

  ssr_state_e           state_q, state_d;
  logic [DIG_IDX_W-1:0] dig_q, dig_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    dig_d   = dig_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_CMUL;
        end
      end
      ST_CMUL:    state_d = ST_CDIV;
      ST_CDIV:    state_d = ST_CSUB;
      ST_CSUB:    state_d = stat_i.primed ? ST_AMUL : ST_FMUL;
      ST_AMUL:    state_d = ST_ADIV_LD;
      ST_ADIV_LD: state_d = ST_ADIV;
      ST_ADIV: begin
        if (!stat_i.div_busy) begin
          state_d = ST_AUPD;
        end
      end
      ST_AUPD:    state_d = ST_FMUL;
      ST_FMUL:    state_d = ST_FRND;
      ST_FRND: begin
        state_d = ST_DST;
        dig_d   = '0;
      end
      ST_DST: begin
        if (dig_q == DIG_IDX_W'(DIGITS - 1)) begin
          state_d = ST_OUT;
        end else begin
          dig_d = dig_q + DIG_IDX_W'(1);
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.dig_idx = dig_q;
    in_stall_o    = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.in_load = in_valid_i;
      end
      ST_CMUL:    cmd_o.cel_mul = 1'b1;
      ST_CDIV:    cmd_o.cel_div = 1'b1;
      ST_CSUB:    cmd_o.cel_store = 1'b1;
      ST_AMUL:    cmd_o.avg_mul = 1'b1;
      ST_ADIV_LD: cmd_o.div_start = 1'b1;
      ST_AUPD:    cmd_o.avg_store = 1'b1;
      ST_FMUL:    cmd_o.fah_mul = 1'b1;
      ST_FRND:    cmd_o.fah_round = 1'b1;
      ST_DST:     cmd_o.dig_store = 1'b1;
      ST_OUT:     cmd_o.out_load = out_free;
      default: begin
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      dig_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dig_q       <= dig_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[hw/rtl/sensor_smoothing_seven_segment_readout.sv]
// ----------------------------------------------------------------------------
// sensor_smoothing_seven_segment_readout
// Smoothed temperature readout driving three active-low seven-segment digits.
// ----------------------------------------------------------------------------
// Each accepted sample is processed until its result is loaded into the output
// register (the first sample after reset loads the average directly and skips
// the average update), and the next sample is accepted only after that load,
// so one sample is in process at a time; a stall on the output side holds the
// load. The serial divider of the average update produces one quotient bit per
// cycle over 37 steps. The divisions by ten in the Celsius scaling and in the
// digit split use reciprocal multiplication, one multiplication for the scaling
// and one per digit. A finished result waits in the output register while the
// next sample is already being processed.
module sensor_smoothing_seven_segment_readout
  import ssr_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [VREF_W-1:0]      cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [SAMPLE_BITS-1:0] adc_sample_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [SEG_W-1:0]       hundreds_segments_o,
  output logic [SEG_W-1:0]       tens_segments_o,
  output logic [SEG_W-1:0]       units_segments_o,
  output logic [OUT_W-1:0]       reading_tenths_o
);

  ssr_cmd_t  cmd;
  ssr_stat_t stat;

  ssr_controller u_controller (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ssr_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .adc_sample_i        (adc_sample_i),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .hundreds_segments_o (hundreds_segments_o),
    .tens_segments_o     (tens_segments_o),
    .units_segments_o    (units_segments_o),
    .reading_tenths_o    (reading_tenths_o)
  );

endmodule
